### src/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

   localparam int NUM_STAGES = 6;

   localparam int HUE_BITS = 16;
   localparam int OUT_BITS = 8;
   localparam int SECTOR_SPAN = 60;

   localparam logic [8:0] HUE_FULL_TURN = 9'd360;
   localparam logic [6:0] HUE_HALF_SECTOR = 7'd60;
   localparam logic [6:0] HUE_TWO_SECTORS = 7'd120;

   // floor(mag/360) == (mag * 11651) >> 22 for mag <= 32768
   localparam logic [13:0] RECIP_360 = 14'd11651;
   localparam int RECIP_360_SHIFT = 22;
   localparam int HUE_QUOT_BITS = 7;

   // floor(z/15) == (z * 4370) >> 16 for z < 4096
   localparam logic [12:0] RECIP_15 = 13'd4370;
   localparam int RECIP_15_SHIFT = 16;

   typedef enum logic [2:0] {
      SECTOR_RY = 3'd0,
      SECTOR_YG = 3'd1,
      SECTOR_GC = 3'd2,
      SECTOR_CB = 3'd3,
      SECTOR_BM = 3'd4,
      SECTOR_MR = 3'd5
   } sector_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [NUM_STAGES-1:0] valid;
   } pipe_ctrl_type;

endpackage

### src/hsv2rgb_stage_ctrl.sv
module hsv2rgb_stage_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic                       out_ready,
   output hsv2rgb_pkg::pipe_ctrl_type ctrl
);

   localparam int N = hsv2rgb_pkg::NUM_STAGES;

   logic [N-1:0] valid_ff;
   logic [N-1:0] valid_in;
   logic [N-1:0] ready;

   always_comb begin
      ready[N-1] = !valid_ff[N-1] || out_ready;
      for (int i = N - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      valid_in[0] = ready[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < N; i++) begin
         valid_in[i] = ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready   = ready[0];
   assign ctrl.load  = ready;
   assign ctrl.valid = valid_ff;

endmodule

### src/hsv_to_rgb_converter_top.sv
// HSV to RGB pixel converter.
// Input beat on req_*: signed hue in whole degrees, saturation and value
// levels. Output beat on rsp_*: red, green and blue levels, plus a flag in
// rsp_tuser that marks a negative hue not a multiple of 360 (pixel forced
// to black). Levels use COLOR_BITS bits of the 8-bit fields; all ones
// means 1.0.
// Throughput: one beat per cycle unless stalled, set by the six register
// stages (hue reduction, chroma divide, sector decode, two multiplies,
// channel mix), each of which takes a new beat whenever the stage after
// it moves on. A stalled receiver holds the output register; stages
// behind it keep filling until every stage is occupied, then req_tready
// drops. Empty stages are filled even while the output waits, so no
// bubble is kept. Reset clears all stage valid bits; the data registers
// are not reset. The block is ready for input in the first cycle in
// which reset is low.
module hsv_to_rgb_converter_top #(
   parameter int COLOR_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // hue_degrees[15:0], saturation_level[23:16],
                                   // brightness_level[31:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // red_level[7:0], green_level[15:8],
                                   // blue_level[23:16]
   output logic        rsp_tuser   // hue_error[0]
);

   localparam int LW = (COLOR_BITS < 8) ? COLOR_BITS : 8;
   localparam int PW = 2 * LW;
   localparam int MW = LW + 1 + COLOR_BITS;
   localparam int YW = LW + 6;
   localparam int ZW = LW + 4;
   localparam int XW = ZW + 13;
   localparam int HW = hsv2rgb_pkg::HUE_BITS;
   localparam int QW = hsv2rgb_pkg::HUE_QUOT_BITS;
   localparam int OW = hsv2rgb_pkg::OUT_BITS;
   localparam logic [MW-1:0] FULL = MW'((64'd1 << COLOR_BITS) - 64'd1);

   hsv2rgb_pkg::pipe_ctrl_type ctrl;

   hsv2rgb_stage_ctrl u_stage_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_ready (rsp_tready),
      .ctrl      (ctrl)
   );

   // stage 1: level product, hue magnitude and coarse turn count
   logic [HW-1:0]   hue_raw;
   logic [LW-1:0]   sat_lvl;
   logic [LW-1:0]   val_lvl;
   logic [29:0]     turn_prod;
   logic [PW-1:0]   s1_prod_ff, s1_prod_in;
   logic [LW-1:0]   s1_val_ff, s1_val_in;
   logic [HW-1:0]   s1_mag_ff, s1_mag_in;
   logic [QW-1:0]   s1_turns_ff, s1_turns_in;
   logic            s1_neg_ff, s1_neg_in;

   always_comb begin
      hue_raw     = req_tdata[15:0];
      sat_lvl     = req_tdata[16 +: LW];
      val_lvl     = req_tdata[24 +: LW];
      s1_neg_in   = hue_raw[HW-1];
      s1_mag_in   = s1_neg_in ? (~hue_raw + HW'(1)) : hue_raw;
      turn_prod   = 30'(s1_mag_in) * 30'(hsv2rgb_pkg::RECIP_360);
      s1_turns_in = turn_prod[hsv2rgb_pkg::RECIP_360_SHIFT +: QW];
      s1_prod_in  = PW'(sat_lvl) * PW'(val_lvl);
      s1_val_in   = val_lvl;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         s1_prod_ff  <= s1_prod_in;
         s1_val_ff   <= s1_val_in;
         s1_mag_ff   <= s1_mag_in;
         s1_turns_ff <= s1_turns_in;
         s1_neg_ff   <= s1_neg_in;
      end
   end

   // stage 2: hue mod 360, chroma quotient estimate
   logic [PW:0]     est_sum;
   logic [HW-1:0]   hue_rem;
   logic [8:0]      s2_hue_ff, s2_hue_in;
   logic [LW-1:0]   s2_qest_ff, s2_qest_in;
   logic [PW-1:0]   s2_prod_ff, s2_prod_in;
   logic [LW-1:0]   s2_val_ff, s2_val_in;
   logic            s2_neg_ff, s2_neg_in;

   always_comb begin
      hue_rem    = s1_mag_ff - HW'(s1_turns_ff) * HW'(hsv2rgb_pkg::HUE_FULL_TURN);
      s2_hue_in  = hue_rem[8:0];
      est_sum    = {1'b0, s1_prod_ff} + (PW+1)'(s1_prod_ff >> COLOR_BITS);
      s2_qest_in = LW'(est_sum >> COLOR_BITS);
      s2_prod_in = s1_prod_ff;
      s2_val_in  = s1_val_ff;
      s2_neg_in  = s1_neg_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         s2_hue_ff  <= s2_hue_in;
         s2_qest_ff <= s2_qest_in;
         s2_prod_ff <= s2_prod_in;
         s2_val_ff  <= s2_val_in;
         s2_neg_ff  <= s2_neg_in;
      end
   end

   // stage 3: chroma correction, sector decode, secondary weight
   logic [MW-1:0]          next_bound;
   logic [6:0]             hue_in_pair;
   hsv2rgb_pkg::sector_type s3_sector_ff, s3_sector_in;
   logic [6:0]             s3_weight_ff, s3_weight_in;
   logic [LW-1:0]          s3_chroma_ff, s3_chroma_in;
   logic [LW-1:0]          s3_val_ff, s3_val_in;
   logic                   s3_err_ff, s3_err_in;

   always_comb begin
      next_bound   = (MW'(s2_qest_ff) + MW'(1)) * FULL;
      s3_chroma_in = s2_qest_ff + LW'(MW'(s2_prod_ff) >= next_bound);
      priority if (s2_hue_ff < 9'(1 * hsv2rgb_pkg::SECTOR_SPAN)) begin
         s3_sector_in = hsv2rgb_pkg::SECTOR_RY;
      end else if (s2_hue_ff < 9'(2 * hsv2rgb_pkg::SECTOR_SPAN)) begin
         s3_sector_in = hsv2rgb_pkg::SECTOR_YG;
      end else if (s2_hue_ff < 9'(3 * hsv2rgb_pkg::SECTOR_SPAN)) begin
         s3_sector_in = hsv2rgb_pkg::SECTOR_GC;
      end else if (s2_hue_ff < 9'(4 * hsv2rgb_pkg::SECTOR_SPAN)) begin
         s3_sector_in = hsv2rgb_pkg::SECTOR_CB;
      end else if (s2_hue_ff < 9'(5 * hsv2rgb_pkg::SECTOR_SPAN)) begin
         s3_sector_in = hsv2rgb_pkg::SECTOR_BM;
      end else begin
         s3_sector_in = hsv2rgb_pkg::SECTOR_MR;
      end
      unique case (s3_sector_in)
         hsv2rgb_pkg::SECTOR_RY, hsv2rgb_pkg::SECTOR_YG: begin
            hue_in_pair = s2_hue_ff[6:0];
         end
         hsv2rgb_pkg::SECTOR_GC, hsv2rgb_pkg::SECTOR_CB: begin
            hue_in_pair = 7'(s2_hue_ff - 9'(2 * hsv2rgb_pkg::SECTOR_SPAN));
         end
         default: begin
            hue_in_pair = 7'(s2_hue_ff - 9'(4 * hsv2rgb_pkg::SECTOR_SPAN));
         end
      endcase
      // weight = 60 - |hue mod 120 - 60|
      s3_weight_in = (hue_in_pair >= hsv2rgb_pkg::HUE_HALF_SECTOR)
                   ? (hsv2rgb_pkg::HUE_TWO_SECTORS - hue_in_pair) : hue_in_pair;
      s3_err_in    = s2_neg_ff && (s2_hue_ff != 9'd0);
      s3_val_in    = s2_val_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         s3_sector_ff <= s3_sector_in;
         s3_weight_ff <= s3_weight_in;
         s3_chroma_ff <= s3_chroma_in;
         s3_val_ff    <= s3_val_in;
         s3_err_ff    <= s3_err_in;
      end
   end

   // stage 4: chroma * weight, offset
   logic [YW-1:0]          s4_scaled_ff, s4_scaled_in;
   logic [LW-1:0]          s4_offset_ff, s4_offset_in;
   logic [LW-1:0]          s4_chroma_ff, s4_chroma_in;
   hsv2rgb_pkg::sector_type s4_sector_ff, s4_sector_in;
   logic                   s4_err_ff, s4_err_in;

   always_comb begin
      s4_scaled_in = YW'(s3_chroma_ff) * YW'(s3_weight_ff);
      s4_offset_in = s3_val_ff - s3_chroma_ff;
      s4_chroma_in = s3_chroma_ff;
      s4_sector_in = s3_sector_ff;
      s4_err_in    = s3_err_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         s4_scaled_ff <= s4_scaled_in;
         s4_offset_ff <= s4_offset_in;
         s4_chroma_ff <= s4_chroma_in;
         s4_sector_ff <= s4_sector_in;
         s4_err_ff    <= s4_err_in;
      end
   end

   // stage 5: secondary term = scaled / 60 = (scaled / 4) / 15
   logic [XW-1:0]          sec_prod;
   logic [LW-1:0]          s5_second_ff, s5_second_in;
   logic [LW-1:0]          s5_offset_ff, s5_offset_in;
   logic [LW-1:0]          s5_chroma_ff, s5_chroma_in;
   hsv2rgb_pkg::sector_type s5_sector_ff, s5_sector_in;
   logic                   s5_err_ff, s5_err_in;

   always_comb begin
      sec_prod     = XW'(s4_scaled_ff[YW-1:2]) * XW'(hsv2rgb_pkg::RECIP_15);
      s5_second_in = sec_prod[hsv2rgb_pkg::RECIP_15_SHIFT +: LW];
      s5_offset_in = s4_offset_ff;
      s5_chroma_in = s4_chroma_ff;
      s5_sector_in = s4_sector_ff;
      s5_err_in    = s4_err_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         s5_second_ff <= s5_second_in;
         s5_offset_ff <= s5_offset_in;
         s5_chroma_ff <= s5_chroma_in;
         s5_sector_ff <= s5_sector_in;
         s5_err_ff    <= s5_err_in;
      end
   end

   // stage 6: channel mix into the output register
   logic [LW-1:0] red_term, green_term, blue_term;
   logic [OW-1:0] s6_red_ff, s6_red_in;
   logic [OW-1:0] s6_green_ff, s6_green_in;
   logic [OW-1:0] s6_blue_ff, s6_blue_in;
   logic          s6_err_ff, s6_err_in;

   always_comb begin
      red_term   = '0;
      green_term = '0;
      blue_term  = '0;
      unique case (s5_sector_ff)
         hsv2rgb_pkg::SECTOR_RY: begin
            red_term   = s5_chroma_ff;
            green_term = s5_second_ff;
         end
         hsv2rgb_pkg::SECTOR_YG: begin
            red_term   = s5_second_ff;
            green_term = s5_chroma_ff;
         end
         hsv2rgb_pkg::SECTOR_GC: begin
            green_term = s5_chroma_ff;
            blue_term  = s5_second_ff;
         end
         hsv2rgb_pkg::SECTOR_CB: begin
            green_term = s5_second_ff;
            blue_term  = s5_chroma_ff;
         end
         hsv2rgb_pkg::SECTOR_BM: begin
            red_term  = s5_second_ff;
            blue_term = s5_chroma_ff;
         end
         default: begin
            red_term  = s5_chroma_ff;
            blue_term = s5_second_ff;
         end
      endcase
      s6_err_in = s5_err_ff;
      if (s5_err_ff) begin
         s6_red_in   = '0;
         s6_green_in = '0;
         s6_blue_in  = '0;
      end else begin
         s6_red_in   = OW'(red_term + s5_offset_ff);
         s6_green_in = OW'(green_term + s5_offset_ff);
         s6_blue_in  = OW'(blue_term + s5_offset_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         s6_red_ff   <= s6_red_in;
         s6_green_ff <= s6_green_in;
         s6_blue_ff  <= s6_blue_in;
         s6_err_ff   <= s6_err_in;
      end
   end

   assign rsp_tvalid = ctrl.valid[hsv2rgb_pkg::NUM_STAGES-1];
   assign rsp_tdata  = {s6_blue_ff, s6_green_ff, s6_red_ff};
   assign rsp_tuser  = s6_err_ff;

endmodule

### tb/tb_hsv_to_rgb_converter_top.sv
module tb_hsv_to_rgb_converter_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLOR_BITS = 8;
   localparam int FULL_LEVEL = (1 << COLOR_BITS) - 1;
   localparam int RANDOM_PER_PHASE = 176;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       hue_error;
   } rgb_pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;

   logic [31:0]   pending_hsv[$];
   rgb_pixel_type expected_rgb[$];
   logic [31:0]   next_hsv;
   rgb_pixel_type observed_rgb;
   rgb_pixel_type predicted_rgb;

   int send_idle_pct = 21;
   int recv_idle_pct = 88;
   int sent_count = 0;
   int accepted_count = 0;
   int checked_count = 0;
   int black_count = 0;
   int error_count = 0;
   int sector_hits[6] = '{default: 0};

   hsv_to_rgb_converter_top #(
      .COLOR_BITS(COLOR_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [31:0] hsv_beat(int hue, int sat, int val);
      return {val[7:0], sat[7:0], hue[15:0]};
   endfunction

   function automatic rgb_pixel_type predict_rgb(logic [31:0] beat);
      int                      hue;
      int                      mag;
      int                      h;
      int                      sat;
      int                      val;
      int                      chroma;
      int                      d;
      int                      x;
      int                      m;
      int                      r;
      int                      g;
      int                      b;
      rgb_pixel_type           px;
      hsv2rgb_pkg::sector_type sector;
      hue = $signed(beat[15:0]);
      sat = beat[23:16] & FULL_LEVEL;
      val = beat[31:24] & FULL_LEVEL;
      mag = (hue < 0) ? -hue : hue;
      h = mag % 360;
      px = '0;
      if (hue < 0 && h != 0) begin
         px.hue_error = 1'b1;
         black_count++;
         return px;
      end
      chroma = (val * sat) / FULL_LEVEL;
      d = h % 120;
      d = (d >= 60) ? d - 60 : 60 - d;
      x = (chroma * (60 - d)) / 60;
      m = val - chroma;
      r = 0;
      g = 0;
      b = 0;
      sector = hsv2rgb_pkg::sector_type'(h / 60);
      sector_hits[h / 60]++;
      case (sector)
         hsv2rgb_pkg::SECTOR_RY: begin r = chroma; g = x; end
         hsv2rgb_pkg::SECTOR_YG: begin r = x; g = chroma; end
         hsv2rgb_pkg::SECTOR_GC: begin g = chroma; b = x; end
         hsv2rgb_pkg::SECTOR_CB: begin g = x; b = chroma; end
         hsv2rgb_pkg::SECTOR_BM: begin r = x; b = chroma; end
         default: begin r = chroma; b = x; end
      endcase
      r = r + m;
      g = g + m;
      b = b + m;
      px.red = r[7:0];
      px.green = g[7:0];
      px.blue = b[7:0];
      return px;
   endfunction

   function automatic int random_level();
      case ($urandom_range(7))
         0: return 0;
         1: return FULL_LEVEL;
         default: return $urandom_range(255);
      endcase
   endfunction

   function automatic logic [31:0] random_hsv();
      int hue;
      case ($urandom_range(9))
         6, 7: hue = $signed(16'($urandom()));
         8: hue = -360 * $urandom_range(1, 91);
         9: hue = $urandom_range(32767);
         default: hue = $urandom_range(359);
      endcase
      return hsv_beat(hue, random_level(), random_level());
   endfunction

   task automatic drain_input();
      while (pending_hsv.size() != 0 || accepted_count != sent_count)
         @(negedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && accepted_count != sent_count)) begin
         if (pending_hsv.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_hsv = pending_hsv.pop_front();
            req_tdata <= next_hsv;
            req_tvalid <= 1'b1;
            sent_count <= sent_count + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_rgb.push_back(predict_rgb(req_tdata));
            accepted_count <= accepted_count + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            observed_rgb = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tuser};
            if (expected_rgb.size() == 0) begin
               error_count++;
               $display("%0t: unexpected rsp beat r=%0d g=%0d b=%0d err=%0b", $time,
                        observed_rgb.red, observed_rgb.green, observed_rgb.blue,
                        observed_rgb.hue_error);
            end else begin
               predicted_rgb = expected_rgb.pop_front();
               checked_count++;
               if (observed_rgb !== predicted_rgb) begin
                  error_count++;
                  $display("%0t: exp r=%0d g=%0d b=%0d err=%0b, got r=%0d g=%0d b=%0d err=%0b",
                           $time, predicted_rgb.red, predicted_rgb.green,
                           predicted_rgb.blue, predicted_rgb.hue_error,
                           observed_rgb.red, observed_rgb.green, observed_rgb.blue,
                           observed_rgb.hue_error);
               end
            end
         end
      end
   end

   initial begin
      int n;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sector edges, level extremes, wrap and negative hues
      pending_hsv.push_back(hsv_beat(0, 255, 255));
      pending_hsv.push_back(hsv_beat(59, 255, 255));
      pending_hsv.push_back(hsv_beat(60, 255, 255));
      pending_hsv.push_back(hsv_beat(119, 255, 255));
      pending_hsv.push_back(hsv_beat(120, 255, 255));
      pending_hsv.push_back(hsv_beat(179, 255, 200));
      pending_hsv.push_back(hsv_beat(180, 255, 255));
      pending_hsv.push_back(hsv_beat(239, 128, 255));
      pending_hsv.push_back(hsv_beat(240, 255, 255));
      pending_hsv.push_back(hsv_beat(299, 255, 255));
      pending_hsv.push_back(hsv_beat(300, 255, 255));
      pending_hsv.push_back(hsv_beat(359, 255, 255));
      pending_hsv.push_back(hsv_beat(360, 255, 255));
      pending_hsv.push_back(hsv_beat(32767, 255, 255));
      pending_hsv.push_back(hsv_beat(90, 0, 255));
      pending_hsv.push_back(hsv_beat(90, 255, 0));
      pending_hsv.push_back(hsv_beat(210, 0, 0));
      pending_hsv.push_back(hsv_beat(-360, 255, 255));
      pending_hsv.push_back(hsv_beat(-32760, 200, 100));
      pending_hsv.push_back(hsv_beat(-1, 255, 255));
      pending_hsv.push_back(hsv_beat(-32768, 255, 255));
      pending_hsv.push_back(hsv_beat(-359, 1, 1));
      pending_hsv.push_back(hsv_beat(30, 1, 254));
      for (n = 0; n < RANDOM_PER_PHASE; n++)
         pending_hsv.push_back(random_hsv());
      drain_input();

      send_idle_pct = 88;
      recv_idle_pct = 21;
      for (n = 0; n < RANDOM_PER_PHASE; n++)
         pending_hsv.push_back(random_hsv());
      drain_input();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (n = 0; n < RANDOM_PER_PHASE; n++)
         pending_hsv.push_back(random_hsv());
      drain_input();

      while (expected_rgb.size() != 0)
         @(negedge clock);
      repeat (12) @(negedge clock);

      $display("%0d pixels checked, %0d forced black by negative hue", checked_count,
               black_count);
      $display("sector hits: %0d %0d %0d %0d %0d %0d", sector_hits[0], sector_hits[1],
               sector_hits[2], sector_hits[3], sector_hits[4], sector_hits[5]);
      if (error_count == 0) begin
         $display("hsv_to_rgb_converter_top: match");
      end else begin
         $display("hsv_to_rgb_converter_top: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout: %0d beats still expected", expected_rgb.size());
      $display("hsv_to_rgb_converter_top: mismatch");
      $finish;
   end

endmodule

### hsv_to_rgb_converter_top.f
src/hsv2rgb_pkg.sv
src/hsv2rgb_stage_ctrl.sv
src/hsv_to_rgb_converter_top.sv
tb/tb_hsv_to_rgb_converter_top.sv
